[sv/kbtt_pkg.sv]
// Shared constants, payload types and index helpers for the keystroke bigram timing table.
`timescale 1ns / 1ps

package kbtt_pkg;

   localparam int ALPHABET      = 96;
   localparam int TIME_BITS     = 16;
   localparam int FRACTION_BITS = 8;

   localparam int CHAR_W    = 7;
   localparam int KEY_W     = 16;
   localparam int CNT_W     = 16;
   localparam int AVG_OUT_W = 25;

   localparam int SUM_W  = TIME_BITS + 1;
   localparam int AVG_W  = SUM_W + FRACTION_BITS;
   localparam int PROD_W = AVG_W + CNT_W;
   localparam int NUM_W  = PROD_W + 1;
   localparam int DIV_W  = CNT_W + 1;
   localparam int DEPTH  = ALPHABET * ALPHABET;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int STEP_W = $clog2(AVG_W);

   localparam logic [CHAR_W-1:0] FIRST_CODE = CHAR_W'(32);
   localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};

   localparam logic ACT_UPDATE = 1'b0;
   localparam logic ACT_READ   = 1'b1;

   typedef struct packed {
      logic              action;
      logic [CHAR_W-1:0] expected_char;
      logic [CHAR_W-1:0] typed_char;
      logic [KEY_W-1:0]  key_time;
      logic              text_start;
      logic [CHAR_W-1:0] query_first;
      logic [CHAR_W-1:0] query_second;
   } kbtt_req_type;

   typedef struct packed {
      logic                 entry_valid;
      logic [CHAR_W-1:0]    pair_first;
      logic [CHAR_W-1:0]    pair_second;
      logic [AVG_OUT_W-1:0] average_time;
      logic [CNT_W-1:0]     occurrences;
      logic [CNT_W-1:0]     miss_count;
   } kbtt_rsp_type;

   typedef struct packed {
      logic [AVG_W-1:0] avg;
      logic [CNT_W-1:0] occ;
      logic [CNT_W-1:0] miss;
   } kbtt_entry_type;

   function automatic logic char_ok(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] pos;
      pos = c - FIRST_CODE;
      return (c >= FIRST_CODE) && ({1'b0, pos} < (CHAR_W + 1)'(ALPHABET));
   endfunction

   function automatic logic [IDX_W-1:0] pair_index(input logic [CHAR_W-1:0] a,
                                                   input logic [CHAR_W-1:0] b);
      logic [CHAR_W-1:0] pa;
      logic [CHAR_W-1:0] pb;
      pa = a - FIRST_CODE;
      pb = b - FIRST_CODE;
      return IDX_W'(pa) * IDX_W'(ALPHABET) + IDX_W'(pb);
   endfunction

endpackage

[sv/kbtt_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module kbtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/keystroke_bigram_timing_table.sv]
// Top level: keystroke pair timing table with sequencer and shift-subtract divider.
// Update of a pair: fetch, load and multiply, setup, 25 divider steps, write, then the result;
// a saturated entry skips the divider. Read of an entry: fetch, load, then the result.
// Text start or a character outside the alphabet: result straight from idle, busy stays low.
// busy drops with the result strobe; a new request is taken only once busy is low.
// After reset the table is cleared, one entry a cycle, all 9216 entries, with busy high.
`timescale 1ns / 1ps

module keystroke_bigram_timing_table (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  kbtt_pkg::kbtt_req_type req_item,
   output logic                  rsp_strobe,
   output kbtt_pkg::kbtt_rsp_type rsp_item
);

   import kbtt_pkg::*;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_FETCH = 7'b0000100,
      ST_LOAD  = 7'b0001000,
      ST_SETUP = 7'b0010000,
      ST_DIV   = 7'b0100000,
      ST_WRITE = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      clr_ff, clr_in;
   logic [CHAR_W-1:0]     prev_exp_ff, prev_exp_in;
   logic [CHAR_W-1:0]     prev_typ_ff, prev_typ_in;
   logic [TIME_BITS-1:0]  prev_time_ff, prev_time_in;
   logic                  prev_present_ff, prev_present_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;

   kbtt_rsp_type          rsp_ff, rsp_in;
   logic                  read_ff, read_in;
   logic [CHAR_W-1:0]     first_ff, first_in;
   logic [CHAR_W-1:0]     second_ff, second_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  miss_ff, miss_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   kbtt_entry_type        entry_ff, entry_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [DIV_W-1:0]      rem_ff, rem_in;
   logic [AVG_W-1:0]      quo_ff, quo_in;
   logic [DIV_W-1:0]      div_ff, div_in;
   logic [STEP_W-1:0]     step_ff, step_in;

   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_wr_addr;
   kbtt_entry_type        ram_wr_data;
   kbtt_entry_type        ram_rd_data;

   logic                  accept;
   logic [TIME_BITS-1:0]  t_cur;
   logic [NUM_W-1:0]      num;
   logic [DIV_W:0]        trial;
   logic                  trial_ge;
   kbtt_entry_type        new_entry;
   logic                  sat;

   kbtt_ram #(
      .WIDTH ($bits(kbtt_entry_type)),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign t_cur      = TIME_BITS'(req_item.key_time);
   assign num        = NUM_W'(prod_ff) + (NUM_W'(sum_ff) << FRACTION_BITS);
   assign trial      = {rem_ff, quo_ff[AVG_W-1]};
   assign trial_ge   = (trial >= {1'b0, div_ff});
   assign sat        = (entry_ff.occ == CNT_MAX);

   always_comb begin
      new_entry = entry_ff;
      if (!sat) begin
         new_entry.avg = quo_ff;
         new_entry.occ = entry_ff.occ + CNT_W'(1);
      end
      if (miss_ff && (entry_ff.miss != CNT_MAX)) begin
         new_entry.miss = entry_ff.miss + CNT_W'(1);
      end
   end

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = new_entry;
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ff;
         ram_wr_data = '0;
      end else if (state_ff == ST_WRITE) begin
         ram_wr_en   = 1'b1;
      end
   end

   always_comb begin
      state_in        = state_ff;
      clr_in          = clr_ff;
      prev_exp_in     = prev_exp_ff;
      prev_typ_in     = prev_typ_ff;
      prev_time_in    = prev_time_ff;
      prev_present_in = prev_present_ff;
      rsp_strobe_in   = 1'b0;
      rsp_in          = rsp_ff;
      read_in         = read_ff;
      first_in        = first_ff;
      second_in       = second_ff;
      idx_in          = idx_ff;
      miss_in         = miss_ff;
      sum_in          = sum_ff;
      entry_in        = entry_ff;
      prod_in         = prod_ff;
      rem_in          = rem_ff;
      quo_in          = quo_ff;
      div_in          = div_ff;
      step_in         = step_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_item.action == ACT_READ) begin
                  first_in  = req_item.query_first;
                  second_in = req_item.query_second;
                  read_in   = 1'b1;
                  if (char_ok(req_item.query_first) && char_ok(req_item.query_second)) begin
                     idx_in   = pair_index(req_item.query_first, req_item.query_second);
                     state_in = ST_FETCH;
                  end else begin
                     rsp_strobe_in = 1'b1;
                     rsp_in        = '0;
                     rsp_in.pair_first  = req_item.query_first;
                     rsp_in.pair_second = req_item.query_second;
                  end
               end else begin
                  read_in   = 1'b0;
                  first_in  = prev_exp_ff;
                  second_in = req_item.expected_char;
                  miss_in   = (prev_exp_ff != prev_typ_ff) ||
                              (req_item.expected_char != req_item.typed_char);
                  sum_in    = SUM_W'(prev_time_ff) + SUM_W'(t_cur);
                  if (req_item.text_start || !prev_present_ff) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in        = '0;
                  end else if (char_ok(prev_exp_ff) && char_ok(req_item.expected_char)) begin
                     idx_in   = pair_index(prev_exp_ff, req_item.expected_char);
                     state_in = ST_FETCH;
                  end else begin
                     rsp_strobe_in = 1'b1;
                     rsp_in        = '0;
                     rsp_in.pair_first  = prev_exp_ff;
                     rsp_in.pair_second = req_item.expected_char;
                  end
                  prev_exp_in     = req_item.expected_char;
                  prev_typ_in     = req_item.typed_char;
                  prev_time_in    = t_cur;
                  prev_present_in = 1'b1;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            entry_in = ram_rd_data;
            prod_in  = PROD_W'(ram_rd_data.avg) * PROD_W'(ram_rd_data.occ);
            if (read_ff) begin
               rsp_strobe_in       = 1'b1;
               rsp_in.entry_valid  = 1'b1;
               rsp_in.pair_first   = first_ff;
               rsp_in.pair_second  = second_ff;
               rsp_in.average_time = AVG_OUT_W'(ram_rd_data.avg);
               rsp_in.occurrences  = ram_rd_data.occ;
               rsp_in.miss_count   = ram_rd_data.miss;
               state_in            = ST_IDLE;
            end else begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            rem_in  = num[NUM_W-1:AVG_W];
            quo_in  = num[AVG_W-1:0];
            div_in  = DIV_W'(entry_ff.occ) + DIV_W'(1);
            step_in = STEP_W'(AVG_W - 1);
            state_in = sat ? ST_WRITE : ST_DIV;
         end
         ST_DIV: begin
            rem_in  = trial_ge ? DIV_W'(trial - {1'b0, div_ff}) : DIV_W'(trial);
            quo_in  = {quo_ff[AVG_W-2:0], trial_ge};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            rsp_strobe_in       = 1'b1;
            rsp_in.entry_valid  = 1'b1;
            rsp_in.pair_first   = first_ff;
            rsp_in.pair_second  = second_ff;
            rsp_in.average_time = AVG_OUT_W'(new_entry.avg);
            rsp_in.occurrences  = new_entry.occ;
            rsp_in.miss_count   = new_entry.miss;
            state_in            = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_ff          <= '0;
         prev_exp_ff     <= '0;
         prev_typ_ff     <= '0;
         prev_time_ff    <= '0;
         prev_present_ff <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clr_ff          <= clr_in;
         prev_exp_ff     <= prev_exp_in;
         prev_typ_ff     <= prev_typ_in;
         prev_time_ff    <= prev_time_in;
         prev_present_ff <= prev_present_in;
         rsp_strobe_ff   <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff    <= rsp_in;
      read_ff   <= read_in;
      first_ff  <= first_in;
      second_ff <= second_in;
      idx_ff    <= idx_in;
      miss_ff   <= miss_in;
      sum_ff    <= sum_in;
      entry_ff  <= entry_in;
      prod_ff   <= prod_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      div_ff    <= div_in;
      step_ff   <= step_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   a_rsp_follows_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(accept) || $fell(busy)))
      else $error("result strobe without a finished transaction");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < div_ff))
      else $error("divider remainder not below divisor");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.entry_valid) |->
         (rsp_item.average_time == '0 && rsp_item.occurrences == '0 &&
          rsp_item.miss_count == '0))
      else $error("invalid result carries statistics");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |=> !rsp_strobe)
      else $error("result during table clear");

endmodule

[tb/keystroke_bigram_timing_table_tb.sv]
// Testbench for the keystroke bigram timing table: directed table, random texts, scoreboard.
`timescale 1ns / 1ps

module keystroke_bigram_timing_table_tb;
   import kbtt_pkg::*;

   localparam int STALL_LIMIT  = 50000;
   localparam int RANDOM_ITEMS = 1000;
   localparam int POOL_SIZE    = 8;
   localparam int MAX_REPORTS  = 100;
   localparam int SETTLE       = 40;

   typedef struct {
      kbtt_req_type req;
      int           repeats;
      bit           pinned;
      kbtt_rsp_type literal;
   } plan_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   kbtt_req_type req_item = '0;
   logic         rsp_strobe;
   kbtt_rsp_type rsp_item;

   bit           pin_check = 1'b0;
   kbtt_rsp_type pin_rsp = '0;

   kbtt_rsp_type entries_due[$];
   plan_row_type plan_rows[$];
   int           mismatches = 0;
   int           stalled_cycles = 0;
   int           calm_left = 0;

   bit [AVG_OUT_W-1:0] mean_table [0:DEPTH-1];
   bit [CNT_W-1:0]     count_table [0:DEPTH-1];
   bit [CNT_W-1:0]     miss_table [0:DEPTH-1];
   bit [CHAR_W-1:0]    last_expected = '0;
   bit [CHAR_W-1:0]    last_typed = '0;
   bit [KEY_W-1:0]     last_ticks = '0;
   bit                 last_present = 1'b0;

   keystroke_bigram_timing_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit in_alphabet(logic [CHAR_W-1:0] c);
      return int'(c) >= int'(FIRST_CODE) && int'(c) - int'(FIRST_CODE) < ALPHABET;
   endfunction

   function automatic int slot_of(logic [CHAR_W-1:0] a, logic [CHAR_W-1:0] b);
      return (int'(a) - int'(FIRST_CODE)) * ALPHABET + (int'(b) - int'(FIRST_CODE));
   endfunction

   function automatic kbtt_rsp_type table_step(kbtt_req_type r);
      kbtt_rsp_type      o;
      int                slot;
      longint unsigned   n;
      longint unsigned   pair_sum;
      o = '0;
      if (r.action == ACT_READ) begin
         o.pair_first  = r.query_first;
         o.pair_second = r.query_second;
         if (in_alphabet(r.query_first) && in_alphabet(r.query_second)) begin
            slot = slot_of(r.query_first, r.query_second);
            o.entry_valid  = 1'b1;
            o.average_time = mean_table[slot];
            o.occurrences  = count_table[slot];
            o.miss_count   = miss_table[slot];
         end
         return o;
      end
      if (!r.text_start && last_present) begin
         o.pair_first  = last_expected;
         o.pair_second = r.expected_char;
         if (in_alphabet(last_expected) && in_alphabet(r.expected_char)) begin
            slot = slot_of(last_expected, r.expected_char);
            n = count_table[slot];
            if (n < CNT_MAX) begin
               pair_sum = last_ticks;
               pair_sum = (pair_sum + r.key_time) << FRACTION_BITS;
               mean_table[slot]  = AVG_OUT_W'((mean_table[slot] * n + pair_sum) / (n + 1));
               count_table[slot] = CNT_W'(n + 1);
            end
            if ((last_expected != last_typed || r.expected_char != r.typed_char) &&
                miss_table[slot] != CNT_MAX)
               miss_table[slot] = miss_table[slot] + 1'b1;
            o.entry_valid  = 1'b1;
            o.average_time = mean_table[slot];
            o.occurrences  = count_table[slot];
            o.miss_count   = miss_table[slot];
         end
      end
      last_expected = r.expected_char;
      last_typed    = r.typed_char;
      last_ticks    = r.key_time;
      last_present  = 1'b1;
      return o;
   endfunction

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : scoreboard
      kbtt_rsp_type want;
      bit           moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_strobe) begin
            moved = 1'b1;
            if (entries_due.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: no transaction outstanding, expected none, actual %h",
                           $time, rsp_item);
            end else begin
               want = entries_due.pop_front();
               check_field("entry_valid", want.entry_valid, rsp_item.entry_valid);
               check_field("pair_first", want.pair_first, rsp_item.pair_first);
               check_field("pair_second", want.pair_second, rsp_item.pair_second);
               check_field("average_time", want.average_time, rsp_item.average_time);
               check_field("occurrences", want.occurrences, rsp_item.occurrences);
               check_field("miss_count", want.miss_count, rsp_item.miss_count);
            end
         end
         if (start && !busy) begin
            moved = 1'b1;
            want = table_step(req_item);
            entries_due.push_back(pin_check ? pin_rsp : want);
         end
         stalled_cycles = moved ? 0 : stalled_cycles + 1;
         if (stalled_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   function automatic kbtt_req_type stroke(int want, int got, int ticks, bit fresh);
      kbtt_req_type r;
      r = '0;
      r.action        = ACT_UPDATE;
      r.expected_char = CHAR_W'(want);
      r.typed_char    = CHAR_W'(got);
      r.key_time      = KEY_W'(ticks);
      r.text_start    = fresh;
      return r;
   endfunction

   function automatic kbtt_req_type lookup(int first, int second);
      kbtt_req_type r;
      r = '0;
      r.action       = ACT_READ;
      r.query_first  = CHAR_W'(first);
      r.query_second = CHAR_W'(second);
      return r;
   endfunction

   function automatic kbtt_rsp_type entry(bit valid, int first, int second, int mean,
                                          int hits, int misses);
      kbtt_rsp_type o;
      o.entry_valid  = valid;
      o.pair_first   = CHAR_W'(first);
      o.pair_second  = CHAR_W'(second);
      o.average_time = AVG_OUT_W'(mean);
      o.occurrences  = CNT_W'(hits);
      o.miss_count   = CNT_W'(misses);
      return o;
   endfunction

   task automatic add_row(input kbtt_req_type r, input int repeats, input bit pinned,
                          input kbtt_rsp_type literal);
      plan_row_type row;
      row.req     = r;
      row.repeats = repeats;
      row.pinned  = pinned;
      row.literal = literal;
      plan_rows.push_back(row);
   endtask

   function automatic int idle_gap();
      int pick;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         calm_left = $urandom_range(15, 50);
         return 0;
      end
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [KEY_W-1:0] pick_ticks();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 13) return KEY_W'($urandom_range(0, 400));
      if (pick < 19) return KEY_W'($urandom_range(0, 65535));
      return $urandom_range(0, 1) ? {KEY_W{1'b1}} : '0;
   endfunction

   task automatic offer(input kbtt_req_type item, input bit pinned,
                        input kbtt_rsp_type literal, input int idle);
      start     <= 1'b1;
      req_item  <= item;
      pin_check <= pinned;
      pin_rsp   <= literal;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (idle > 0) begin
         start <= 1'b0;
         repeat (idle) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(negedge clock);
      while (entries_due.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   initial begin : stimulus
      kbtt_req_type    item;
      kbtt_req_type    junk_read;
      bit [63:0]       noise_bits;
      logic [CHAR_W-1:0] pool [0:POOL_SIZE-1];
      int              sent;
      int              pick;
      int              strokes;
      int              k;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      junk_read = lookup(127, 32);
      junk_read.text_start    = 1'b1;
      junk_read.typed_char    = CHAR_W'(127);
      junk_read.key_time      = {KEY_W{1'b1}};

      add_row(lookup(32, 127), 1, 1'b1, entry(1'b1, 32, 127, 0, 0, 0));
      add_row(lookup(0, 127), 1, 1'b1, entry(1'b0, 0, 127, 0, 0, 0));
      add_row(stroke(97, 97, 100, 1'b0), 1, 1'b1, entry(1'b0, 0, 0, 0, 0, 0));
      add_row(stroke(98, 98, 200, 1'b0), 1, 1'b1, entry(1'b1, 97, 98, 76800, 1, 0));
      add_row(stroke(99, 120, 65535, 1'b0), 1, 1'b1,
              entry(1'b1, 98, 99, 16828160, 1, 1));
      add_row(stroke(100, 100, 0, 1'b1), 1, 1'b1, entry(1'b0, 0, 0, 0, 0, 0));
      add_row(stroke(101, 101, 0, 1'b0), 1, 1'b1, entry(1'b1, 100, 101, 0, 1, 0));
      add_row(stroke(5, 5, 10, 1'b0), 1, 1'b1, entry(1'b0, 101, 5, 0, 0, 0));
      add_row(stroke(127, 127, 0, 1'b0), 1, 1'b1, entry(1'b0, 5, 127, 0, 0, 0));
      add_row(stroke(32, 33, 65535, 1'b0), 1, 1'b1,
              entry(1'b1, 127, 32, 16776960, 1, 1));
      add_row(junk_read, 1, 1'b1, entry(1'b1, 127, 32, 16776960, 1, 1));
      add_row(stroke(32, 32, 65535, 1'b0), 1, 1'b1,
              entry(1'b1, 32, 32, 33553920, 1, 1));
      add_row(stroke(97, 97, 50, 1'b1), 1, 1'b1, entry(1'b0, 0, 0, 0, 0, 0));
      add_row(stroke(98, 98, 51, 1'b0), 1, 1'b0, '0);
      add_row(lookup(97, 98), 1, 1'b0, '0);
      add_row(stroke(127, 31, 7, 1'b0), 1, 1'b0, '0);
      add_row(stroke(122, 122, 1000, 1'b1), 1, 1'b1, entry(1'b0, 0, 0, 0, 0, 0));
      add_row(stroke(122, 122, 1000, 1'b0), 10, 1'b0, '0);
      add_row(stroke(122, 121, 1000, 1'b0), 20, 1'b0, '0);
      add_row(lookup(122, 122), 1, 1'b1, entry(1'b1, 122, 122, 512000, 30, 20));
      add_row(stroke(122, 122, 65535, 1'b0), 1, 1'b0, '0);

      foreach (plan_rows[i])
         for (k = 0; k < plan_rows[i].repeats; k++)
            offer(plan_rows[i].req, plan_rows[i].pinned, plan_rows[i].literal,
                  plan_rows[i].repeats > 1 ? 0 : idle_gap());

      wait_drained();

      for (k = 0; k < POOL_SIZE; k++)
         pool[k] = CHAR_W'($urandom_range(32, 127));

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 2)
            wait_drained();
         noise_bits = {$urandom, $urandom};
         item = noise_bits[$bits(kbtt_req_type)-1:0];
         if (pick < 70) begin
            strokes = $urandom_range(2, 10);
            for (k = 0; k < strokes; k++) begin
               noise_bits = {$urandom, $urandom};
               item = noise_bits[$bits(kbtt_req_type)-1:0];
               item.action     = ACT_UPDATE;
               item.text_start = (k == 0) ? ($urandom_range(0, 9) != 0)
                                          : ($urandom_range(0, 49) == 0);
               if ($urandom_range(0, 19) != 0)
                  item.expected_char = pool[$urandom_range(0, POOL_SIZE - 1)];
               if ($urandom_range(0, 6) != 0)
                  item.typed_char = item.expected_char;
               item.key_time = pick_ticks();
               offer(item, 1'b0, '0, idle_gap());
            end
            sent += strokes;
         end else if (pick < 88) begin
            item.action = ACT_READ;
            if ($urandom_range(0, 4) != 0) begin
               item.query_first  = pool[$urandom_range(0, POOL_SIZE - 1)];
               item.query_second = pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            offer(item, 1'b0, '0, idle_gap());
            sent++;
         end else begin
            item.action = ACT_UPDATE;
            offer(item, 1'b0, '0, idle_gap());
            sent++;
         end
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && entries_due.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
